[hdl/gcr_pkg.sv]
// Package for the GPIO controller register block: payload structs, state struct,
// register word map, request and pull codes, and the bank helper functions.
// No dependencies.
package gcr_pkg;

	localparam int NUM_PINS = 54;
	localparam int FSEL_PER_WORD = 10;
	localparam int FSEL_WORDS = 7;

	typedef logic [NUM_PINS-1:0] pins_t;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_WRITE = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		PULL_NONE = 2'd0,
		PULL_DOWN = 2'd1,
		PULL_UP   = 2'd2
	} pull_code_t;

	localparam logic [2:0] FSEL_OUTPUT = 3'b001;

	localparam logic [5:0] W_FSEL_LAST = 6'd6;
	localparam logic [5:0] W_SET0      = 6'd7;
	localparam logic [5:0] W_SET1      = 6'd8;
	localparam logic [5:0] W_CLR0      = 6'd10;
	localparam logic [5:0] W_CLR1      = 6'd11;
	localparam logic [5:0] W_LEV0      = 6'd13;
	localparam logic [5:0] W_LEV1      = 6'd14;
	localparam logic [5:0] W_EDS0      = 6'd16;
	localparam logic [5:0] W_EDS1      = 6'd17;
	localparam logic [5:0] W_REN0      = 6'd19;
	localparam logic [5:0] W_REN1      = 6'd20;
	localparam logic [5:0] W_FEN0      = 6'd22;
	localparam logic [5:0] W_FEN1      = 6'd23;
	localparam logic [5:0] W_HEN0      = 6'd25;
	localparam logic [5:0] W_HEN1      = 6'd26;
	localparam logic [5:0] W_LEN0      = 6'd28;
	localparam logic [5:0] W_LEN1      = 6'd29;
	localparam logic [5:0] W_PUD       = 6'd37;
	localparam logic [5:0] W_PUDCLK0   = 6'd38;
	localparam logic [5:0] W_PUDCLK1   = 6'd39;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [5:0]  reg_word;
		logic [31:0] write_data;
		pins_t       pad_in;
	} req_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		pins_t       pad_out;
		pins_t       pad_drive_enable;
		pins_t       pad_pull_up;
		pins_t       pad_pull_down;
		logic        irq;
	} rsp_item_t;

	typedef struct packed {
		logic [3*NUM_PINS-1:0] fsel;
		pins_t                 latch;
		pins_t                 eds;
		pins_t                 ren;
		pins_t                 fen;
		pins_t                 hen;
		pins_t                 len;
		pins_t                 prev;
		logic [1:0]            pud;
		logic [2*NUM_PINS-1:0] pull;
	} gcr_state_t;

	function automatic pins_t bank_bits(input logic [31:0] d, input logic b);
		logic [63:0] t;
		t = b ? {d, 32'h0} : {32'h0, d};
		return t[NUM_PINS-1:0];
	endfunction

	function automatic logic [31:0] bank_read(input pins_t r, input logic b);
		logic [63:0] t;
		t = 64'(r);
		return b ? t[63:32] : t[31:0];
	endfunction

	function automatic pins_t bank_replace(input pins_t r, input logic [31:0] d,
			input logic b);
		pins_t m;
		m = bank_bits(32'hFFFF_FFFF, b);
		return (r & ~m) | bank_bits(d, b);
	endfunction

endpackage

[hdl/gpio_controller_regs_unit.sv]
// GPIO controller register block, top level: input register, state update,
// result register and handshake. Depends on gcr_pkg, gcr_state,
// gcr_read_mux and gcr_output_map.
//
// Request channel (req_valid, req_stall, req): one beat per clock tick of the
// pads, carrying pad levels and an optional bus read or write at a word offset.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one beat per request,
// in order: read word (zero unless a read of a readable word), the output
// latch, drive enables, pull-up and pull-down outputs, and irq.
// The request is loaded into the input register at acceptance; once the result
// register is free, an edge runs the single-pass state update and loads the
// result register, which raises rsp_valid. Throughput is one beat per cycle
// while the response side is not stalled; the state registers are updated
// once per beat as it moves into the result register.
// A stalled response holds in the result register; one further request is
// taken into the input register, after which req_stall is raised until the
// response side moves again. Reset clears all GPIO state to zero (all pins
// inputs, no pull, no events) and empties both stages.
module gpio_controller_regs_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  gcr_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output gcr_pkg::rsp_item_t rsp
);

	logic                valid_s1;
	gcr_pkg::req_item_t  req_s1;
	logic                valid_s2;
	gcr_pkg::rsp_item_t  rsp_s2;
	logic                s2_free;
	logic                fire;
	gcr_pkg::gcr_state_t st;
	gcr_pkg::gcr_state_t nxt;
	logic [31:0]         rd;
	gcr_pkg::rsp_item_t  result;
	gcr_pkg::pins_t      drive;
	gcr_pkg::pins_t      pull_up;
	gcr_pkg::pins_t      pull_down;
	logic                irq;

	assign s2_free   = !valid_s2 || !rsp_stall;
	assign fire      = valid_s1 && s2_free;
	assign req_stall = valid_s1 && !s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	gcr_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.st     (st),
		.nxt    (nxt)
	);

	gcr_read_mux u_read_mux (
		.st   (st),
		.word (req_s1.reg_word),
		.pads (req_s1.pad_in),
		.rd   (rd)
	);

	gcr_output_map u_output_map (
		.st        (nxt),
		.drive     (drive),
		.pull_up   (pull_up),
		.pull_down (pull_down),
		.irq       (irq)
	);

	always_comb begin
		result.read_data        = (req_s1.req_type == gcr_pkg::REQ_READ) ? rd : 32'h0;
		result.pad_out          = nxt.latch;
		result.pad_drive_enable = drive;
		result.pad_pull_up      = pull_up;
		result.pad_pull_down    = pull_down;
		result.irq              = irq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

[hdl/gcr_read_mux.sv]
// Register read multiplexer: selects the bus read word from the current state
// and the beat's pad levels. Depends on gcr_pkg.
module gcr_read_mux (
	input  gcr_pkg::gcr_state_t st,
	input  logic [5:0]          word,
	input  gcr_pkg::pins_t      pads,
	output logic [31:0]         rd
);

	logic [31:0] fw [gcr_pkg::FSEL_WORDS];

	always_comb begin
		for (int w = 0; w < gcr_pkg::FSEL_WORDS; w++) begin
			fw[w] = '0;
			for (int k = 0; k < gcr_pkg::FSEL_PER_WORD; k++) begin
				if (w * gcr_pkg::FSEL_PER_WORD + k < gcr_pkg::NUM_PINS) begin
					fw[w][3*k +: 3] = st.fsel[3*(w*gcr_pkg::FSEL_PER_WORD + k) +: 3];
				end
			end
		end
	end

	always_comb begin
		rd = '0;
		if (word <= gcr_pkg::W_FSEL_LAST) begin
			rd = fw[word[2:0]];
		end else begin
			unique case (word)
				gcr_pkg::W_LEV0:  rd = gcr_pkg::bank_read(pads, 1'b0);
				gcr_pkg::W_LEV1:  rd = gcr_pkg::bank_read(pads, 1'b1);
				gcr_pkg::W_EDS0:  rd = gcr_pkg::bank_read(st.eds, 1'b0);
				gcr_pkg::W_EDS1:  rd = gcr_pkg::bank_read(st.eds, 1'b1);
				gcr_pkg::W_REN0:  rd = gcr_pkg::bank_read(st.ren, 1'b0);
				gcr_pkg::W_REN1:  rd = gcr_pkg::bank_read(st.ren, 1'b1);
				gcr_pkg::W_FEN0:  rd = gcr_pkg::bank_read(st.fen, 1'b0);
				gcr_pkg::W_FEN1:  rd = gcr_pkg::bank_read(st.fen, 1'b1);
				gcr_pkg::W_HEN0:  rd = gcr_pkg::bank_read(st.hen, 1'b0);
				gcr_pkg::W_HEN1:  rd = gcr_pkg::bank_read(st.hen, 1'b1);
				gcr_pkg::W_LEN0:  rd = gcr_pkg::bank_read(st.len, 1'b0);
				gcr_pkg::W_LEN1:  rd = gcr_pkg::bank_read(st.len, 1'b1);
				gcr_pkg::W_PUD:   rd = {30'h0, st.pud};
				default:          rd = '0;
			endcase
		end
	end

endmodule

[hdl/gcr_state.sv]
// Register state of the GPIO block: bus write decode, event detection and
// the state update taken once per beat. Depends on gcr_pkg.
module gcr_state (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  gcr_pkg::req_item_t  req,
	output gcr_pkg::gcr_state_t st,
	output gcr_pkg::gcr_state_t nxt
);

	gcr_pkg::gcr_state_t st_q;
	gcr_pkg::pins_t      ev;
	gcr_pkg::pins_t      pads;
	gcr_pkg::pins_t      clk_bits;
	logic [31:0]         d;

	assign pads = req.pad_in;
	assign d    = req.write_data;

	assign ev = (pads & ~st_q.prev & st_q.ren) | (~pads & st_q.prev & st_q.fen)
		| (pads & st_q.hen) | (~pads & st_q.len);

	assign clk_bits = gcr_pkg::bank_bits(d, req.reg_word == gcr_pkg::W_PUDCLK1);

	always_comb begin
		nxt = st_q;
		if (req.req_type == gcr_pkg::REQ_WRITE) begin
			if (req.reg_word <= gcr_pkg::W_FSEL_LAST) begin
				for (int w = 0; w < gcr_pkg::FSEL_WORDS; w++) begin
					for (int k = 0; k < gcr_pkg::FSEL_PER_WORD; k++) begin
						if (w * gcr_pkg::FSEL_PER_WORD + k < gcr_pkg::NUM_PINS &&
								req.reg_word[2:0] == 3'(w)) begin
							nxt.fsel[3*(w*gcr_pkg::FSEL_PER_WORD + k) +: 3] = d[3*k +: 3];
						end
					end
				end
			end else begin
				unique case (req.reg_word)
					gcr_pkg::W_SET0: nxt.latch = st_q.latch | gcr_pkg::bank_bits(d, 1'b0);
					gcr_pkg::W_SET1: nxt.latch = st_q.latch | gcr_pkg::bank_bits(d, 1'b1);
					gcr_pkg::W_CLR0: nxt.latch = st_q.latch & ~gcr_pkg::bank_bits(d, 1'b0);
					gcr_pkg::W_CLR1: nxt.latch = st_q.latch & ~gcr_pkg::bank_bits(d, 1'b1);
					gcr_pkg::W_EDS0: nxt.eds = st_q.eds & ~gcr_pkg::bank_bits(d, 1'b0);
					gcr_pkg::W_EDS1: nxt.eds = st_q.eds & ~gcr_pkg::bank_bits(d, 1'b1);
					gcr_pkg::W_REN0: nxt.ren = gcr_pkg::bank_replace(st_q.ren, d, 1'b0);
					gcr_pkg::W_REN1: nxt.ren = gcr_pkg::bank_replace(st_q.ren, d, 1'b1);
					gcr_pkg::W_FEN0: nxt.fen = gcr_pkg::bank_replace(st_q.fen, d, 1'b0);
					gcr_pkg::W_FEN1: nxt.fen = gcr_pkg::bank_replace(st_q.fen, d, 1'b1);
					gcr_pkg::W_HEN0: nxt.hen = gcr_pkg::bank_replace(st_q.hen, d, 1'b0);
					gcr_pkg::W_HEN1: nxt.hen = gcr_pkg::bank_replace(st_q.hen, d, 1'b1);
					gcr_pkg::W_LEN0: nxt.len = gcr_pkg::bank_replace(st_q.len, d, 1'b0);
					gcr_pkg::W_LEN1: nxt.len = gcr_pkg::bank_replace(st_q.len, d, 1'b1);
					gcr_pkg::W_PUD:  nxt.pud = d[1:0];
					gcr_pkg::W_PUDCLK0, gcr_pkg::W_PUDCLK1: begin
						for (int p = 0; p < gcr_pkg::NUM_PINS; p++) begin
							if (clk_bits[p]) begin
								nxt.pull[2*p +: 2] = st_q.pud;
							end
						end
					end
					default: ;
				endcase
			end
		end
		// a new event beats a write-1 clear in the same beat
		nxt.eds  = nxt.eds | ev;
		nxt.prev = pads;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= nxt;
		end
	end

	assign st = st_q;

endmodule

[hdl/gcr_output_map.sv]
// Pad output mapping: drive enables from function selects and pull outputs
// from the per-pin pull settings of the updated state. Depends on gcr_pkg.
module gcr_output_map (
	input  gcr_pkg::gcr_state_t st,
	output gcr_pkg::pins_t      drive,
	output gcr_pkg::pins_t      pull_up,
	output gcr_pkg::pins_t      pull_down,
	output logic                irq
);

	always_comb begin
		for (int p = 0; p < gcr_pkg::NUM_PINS; p++) begin
			drive[p]     = st.fsel[3*p +: 3] == gcr_pkg::FSEL_OUTPUT;
			pull_up[p]   = st.pull[2*p +: 2] == gcr_pkg::PULL_UP;
			pull_down[p] = st.pull[2*p +: 2] == gcr_pkg::PULL_DOWN;
		end
	end

	assign irq = |st.eds;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for gpio_controller_regs_unit: directed and random request beats,
// with every response checked field by field against a shadow of the GPIO register state.
// Depends on gcr_pkg and the RTL under hdl/.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam logic [1:0] PULL_RESERVED = 2'd3;
	localparam logic [63:0] PIN_MASK = (64'd1 << gcr_pkg::NUM_PINS) - 64'd1;
	localparam logic [63:0] ONES = {64{1'b1}};
	localparam int RANDOM_BEATS = 1850;
	localparam int DRAIN_EVERY = 450;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	gcr_pkg::req_item_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	gcr_pkg::rsp_item_t rsp;

	gcr_pkg::req_item_t pending_q[$];
	bit drain_q[$];
	gcr_pkg::rsp_item_t expected_q[$];
	int mismatches = 0;
	bit req_took = 1'b0;
	bit calm = 1'b0;
	int req_gap = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int cycle_count = 0;

	// shadow GPIO state, pin registers kept 64 bits wide with unused bits zero
	logic [2:0] fsel_q [gcr_pkg::NUM_PINS] = '{default: '0};
	logic [1:0] pull_pin_q [gcr_pkg::NUM_PINS] = '{default: '0};
	logic [63:0] latch_q = '0;
	logic [63:0] events_q = '0;
	logic [63:0] rise_q = '0;
	logic [63:0] fall_q = '0;
	logic [63:0] high_q = '0;
	logic [63:0] low_q = '0;
	logic [63:0] last_pads_q = '0;
	logic [1:0] pull_ctl_q = gcr_pkg::PULL_NONE;

	gpio_controller_regs_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic gcr_pkg::rsp_item_t gpio_tick(input gcr_pkg::req_item_t b);
		gcr_pkg::rsp_item_t o;
		logic [63:0] pads, ev, lane, half, src;
		logic [31:0] d;
		logic [5:0] w;
		bit hi;
		int pin, k;
		pads = '0;
		pads[gcr_pkg::NUM_PINS-1:0] = b.pad_in;
		w = b.reg_word;
		d = b.write_data;
		case (w)
			gcr_pkg::W_SET1, gcr_pkg::W_CLR1, gcr_pkg::W_LEV1, gcr_pkg::W_EDS1,
			gcr_pkg::W_REN1, gcr_pkg::W_FEN1, gcr_pkg::W_HEN1, gcr_pkg::W_LEN1,
			gcr_pkg::W_PUDCLK1: hi = 1'b1;
			default: hi = 1'b0;
		endcase
		lane = (hi ? {d, 32'h0} : {32'h0, d}) & PIN_MASK;
		half = hi ? 64'hFFFF_FFFF_0000_0000 : 64'h0000_0000_FFFF_FFFF;
		o = '0;
		if (b.req_type == gcr_pkg::REQ_READ) begin
			case (w)
				gcr_pkg::W_LEV0, gcr_pkg::W_LEV1: src = pads;
				gcr_pkg::W_EDS0, gcr_pkg::W_EDS1: src = events_q;
				gcr_pkg::W_REN0, gcr_pkg::W_REN1: src = rise_q;
				gcr_pkg::W_FEN0, gcr_pkg::W_FEN1: src = fall_q;
				gcr_pkg::W_HEN0, gcr_pkg::W_HEN1: src = high_q;
				gcr_pkg::W_LEN0, gcr_pkg::W_LEN1: src = low_q;
				gcr_pkg::W_PUD: src = {62'd0, pull_ctl_q};
				default: src = '0;
			endcase
			o.read_data = hi ? src[63:32] : src[31:0];
			if (w <= gcr_pkg::W_FSEL_LAST) begin
				for (k = 0; k < gcr_pkg::FSEL_PER_WORD; k++) begin
					pin = int'(w) * gcr_pkg::FSEL_PER_WORD + k;
					if (pin < gcr_pkg::NUM_PINS)
						o.read_data[3*k +: 3] = fsel_q[pin];
				end
			end
		end
		// events see enables and previous pads from before this beat's write
		ev = ((pads & ~last_pads_q & rise_q) | (~pads & last_pads_q & fall_q)
			| (pads & high_q) | (~pads & low_q)) & PIN_MASK;
		if (b.req_type == gcr_pkg::REQ_WRITE) begin
			if (w <= gcr_pkg::W_FSEL_LAST) begin
				for (k = 0; k < gcr_pkg::FSEL_PER_WORD; k++) begin
					pin = int'(w) * gcr_pkg::FSEL_PER_WORD + k;
					if (pin < gcr_pkg::NUM_PINS)
						fsel_q[pin] = d[3*k +: 3];
				end
			end
			case (w)
				gcr_pkg::W_SET0, gcr_pkg::W_SET1: latch_q |= lane;
				gcr_pkg::W_CLR0, gcr_pkg::W_CLR1: latch_q &= ~lane;
				gcr_pkg::W_EDS0, gcr_pkg::W_EDS1: events_q &= ~lane;
				gcr_pkg::W_REN0, gcr_pkg::W_REN1: rise_q = (rise_q & ~half) | lane;
				gcr_pkg::W_FEN0, gcr_pkg::W_FEN1: fall_q = (fall_q & ~half) | lane;
				gcr_pkg::W_HEN0, gcr_pkg::W_HEN1: high_q = (high_q & ~half) | lane;
				gcr_pkg::W_LEN0, gcr_pkg::W_LEN1: low_q = (low_q & ~half) | lane;
				gcr_pkg::W_PUD: pull_ctl_q = d[1:0];
				gcr_pkg::W_PUDCLK0, gcr_pkg::W_PUDCLK1: begin
					for (pin = 0; pin < gcr_pkg::NUM_PINS; pin++)
						if (lane[pin])
							pull_pin_q[pin] = pull_ctl_q;
				end
				default: ;
			endcase
		end
		events_q |= ev;
		last_pads_q = pads;
		o.pad_out = latch_q[gcr_pkg::NUM_PINS-1:0];
		for (pin = 0; pin < gcr_pkg::NUM_PINS; pin++) begin
			o.pad_drive_enable[pin] = (fsel_q[pin] == gcr_pkg::FSEL_OUTPUT);
			o.pad_pull_up[pin] = (pull_pin_q[pin] == gcr_pkg::PULL_UP);
			o.pad_pull_down[pin] = (pull_pin_q[pin] == gcr_pkg::PULL_DOWN);
		end
		o.irq = |events_q;
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_beat(input logic [1:0] kind, input logic [5:0] word,
			input logic [31:0] data, input logic [63:0] pads, input bit drain = 1'b0);
		gcr_pkg::req_item_t b;
		b.req_type = kind;
		b.reg_word = word;
		b.write_data = data;
		b.pad_in = pads[gcr_pkg::NUM_PINS-1:0];
		pending_q.push_back(b);
		drain_q.push_back(drain);
	endtask

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
		end
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_took) begin
				if (req_gap > 0) begin
					req_valid <= 1'b0;
					req_gap--;
				end else if (pending_q.size() == 0
						|| (drain_q[0] && expected_q.size() != 0)) begin
					req_valid <= 1'b0;
				end else begin
					req <= pending_q[0];
					req_valid <= 1'b1;
					void'(pending_q.pop_front());
					void'(drain_q.pop_front());
					req_gap = pick_gap();
				end
			end
		end
	end

	// response back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
				stall_left = pick_gap();
			end
		end
	end

	// monitor: check the response beat, then predict the accepted request beat
	always @(posedge clk) begin
		gcr_pkg::rsp_item_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected response beat, expected none, got %h", $time, rsp);
				end else begin
					want = expected_q.pop_front();
					check_field("read_data", 64'(want.read_data), 64'(rsp.read_data));
					check_field("pad_out", 64'(want.pad_out), 64'(rsp.pad_out));
					check_field("pad_drive_enable", 64'(want.pad_drive_enable),
						64'(rsp.pad_drive_enable));
					check_field("pad_pull_up", 64'(want.pad_pull_up), 64'(rsp.pad_pull_up));
					check_field("pad_pull_down", 64'(want.pad_pull_down),
						64'(rsp.pad_pull_down));
					check_field("irq", 64'(want.irq), 64'(rsp.irq));
				end
			end
			req_took = req_valid && !req_stall;
			if (req_took)
				expected_q.push_back(gpio_tick(req));
		end
	end

	// watchdog and calm stretches
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (cycle_count % 400 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [63:0] pads;
		logic [31:0] data;
		logic [5:0] word;
		logic [1:0] kind;
		logic [5:0] mapped_words[$];
		int i, r;

		pads = '0;
		push_beat(gcr_pkg::REQ_TICK, gcr_pkg::W_FSEL_LAST, '0, pads);
		push_beat(gcr_pkg::REQ_WRITE, 6'd0, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_READ, 6'd0, '0, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_FSEL_LAST - 6'd1, 32'h0924_9249, pads);
		push_beat(gcr_pkg::REQ_READ, gcr_pkg::W_FSEL_LAST - 6'd1, '0, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_FSEL_LAST, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_READ, gcr_pkg::W_FSEL_LAST, '0, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_SET0, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_SET1, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_CLR0, 32'h5555_5555, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_CLR1, 32'hFFFF_0000, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_REN0, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_REN1, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_FEN1, 32'hFFFF_FFFF, pads);
		pads = ONES;
		push_beat(gcr_pkg::REQ_READ, gcr_pkg::W_EDS1, '0, pads);
		push_beat(gcr_pkg::REQ_READ, gcr_pkg::W_EDS0, '0, pads);
		pads = '0;
		// falling edge in the same beat outranks the clear
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_EDS1, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_EDS1, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_EDS0, 32'hFFFF_FFFF, pads);
		pads = 64'h0015_5555_AAAA_AAAA;
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_HEN1, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_LEN0, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_READ, gcr_pkg::W_LEV1, '0, ~pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_PUD, {30'd0, PULL_RESERVED}, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_PUDCLK0, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_PUD, {30'd0, gcr_pkg::PULL_UP}, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_PUDCLK1, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_PUD, {30'd0, gcr_pkg::PULL_DOWN}, pads);
		push_beat(gcr_pkg::REQ_WRITE, gcr_pkg::W_PUDCLK0, 32'hAAAA_AAAA, pads);
		push_beat(gcr_pkg::REQ_READ, gcr_pkg::W_PUD, '0, pads);
		push_beat(REQ_UNKNOWN, gcr_pkg::W_SET0, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_WRITE, 6'd63, 32'hFFFF_FFFF, pads);
		push_beat(gcr_pkg::REQ_READ, 6'd63, '0, pads);

		for (i = 0; i <= gcr_pkg::W_FSEL_LAST; i++)
			mapped_words.push_back(6'(i));
		mapped_words = {mapped_words, gcr_pkg::W_SET0, gcr_pkg::W_SET1, gcr_pkg::W_CLR0,
			gcr_pkg::W_CLR1, gcr_pkg::W_LEV0, gcr_pkg::W_LEV1, gcr_pkg::W_EDS0,
			gcr_pkg::W_EDS1, gcr_pkg::W_REN0, gcr_pkg::W_REN1, gcr_pkg::W_FEN0,
			gcr_pkg::W_FEN1, gcr_pkg::W_HEN0, gcr_pkg::W_HEN1, gcr_pkg::W_LEN0,
			gcr_pkg::W_LEN1, gcr_pkg::W_PUD, gcr_pkg::W_PUDCLK0, gcr_pkg::W_PUDCLK1};

		for (i = 0; i < RANDOM_BEATS; i++) begin
			r = $urandom_range(0, 99);
			word = mapped_words[$urandom_range(0, mapped_words.size() - 1)];
			if (r < 15) begin
				kind = gcr_pkg::REQ_TICK;
			end else if (r < 47) begin
				kind = gcr_pkg::REQ_WRITE;
			end else if (r < 80) begin
				kind = gcr_pkg::REQ_READ;
			end else if (r < 88) begin
				kind = gcr_pkg::REQ_WRITE;
				word = 6'($urandom_range(0, 63));
			end else if (r < 95) begin
				kind = gcr_pkg::REQ_READ;
				word = 6'($urandom_range(0, 63));
			end else begin
				kind = REQ_UNKNOWN;
				word = 6'($urandom_range(0, 63));
			end
			case ($urandom_range(0, 7))
				0: data = '0;
				1: data = '1;
				2, 3: data = $urandom & $urandom & $urandom;
				default: data = $urandom;
			endcase
			case ($urandom_range(0, 9))
				0: pads = '0;
				1: pads = ONES;
				2, 3: pads = {$urandom, $urandom};
				4: ;
				default: pads = pads ^ (64'd1 << $urandom_range(0, gcr_pkg::NUM_PINS - 1))
					^ (64'd1 << $urandom_range(0, gcr_pkg::NUM_PINS - 1));
			endcase
			push_beat(kind, word, data, pads, (i % DRAIN_EVERY) == 0);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() != 0 || req_valid || expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
